FILE: design/upload_receiver_sequencer_top_macros.svh
// assertion macros for the upload receiver sequencer
// clocked on clk, held off while rst_n is low
`ifndef UPLOAD_RECEIVER_SEQUENCER_TOP_MACROS_SVH
`define UPLOAD_RECEIVER_SEQUENCER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// antecedent and consequent in the same cycle
`define URS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent in the cycle after the antecedent
`define URS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define URS_ASSERT_SAME(lbl, ante, cons, msg)
`define URS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: design/urs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package urs_pkg;

  localparam int ID_WIDTH_DEF = 32;
  localparam int MSG_ID_W     = 32;
  localparam int SIZE_W       = 32;
  localparam int BYTE_W       = 8;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 32;

  // register index, taken from paddr above the byte offset
  localparam logic [CFG_ADDR_W-3:0] REG_FIRST_ID = '0;

  typedef enum logic [1:0] {
    PH_WAITING     = 2'd0,
    PH_DOWNLOADING = 2'd1,
    PH_FINISHED    = 2'd2,
    PH_COMPLETE    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    REQ_UPLOAD = 2'd0,
    REQ_DATA   = 2'd1,
    REQ_END    = 2'd2,
    REQ_OTHER  = 2'd3
  } req_t;

  typedef struct packed {
    req_t                req_type;
    logic [MSG_ID_W-1:0] message_id;
    logic [SIZE_W-1:0]   file_size;
    logic [BYTE_W-1:0]   check_sum;
    logic [BYTE_W-1:0]   data_byte;
    logic                seg_last;
  } item_t;

  typedef struct packed {
    phase_t              phase;
    logic [SIZE_W-1:0]   bytes_rcvd;
    logic [SIZE_W-1:0]   dl_size;
    logic [BYTE_W-1:0]   csum;
  } st_t;

  typedef struct packed {
    logic                accepted;
    logic                ack_valid;
    logic [MSG_ID_W-1:0] acked_id;
    logic [MSG_ID_W-1:0] expected_id;
    logic                store_valid;
    logic [BYTE_W-1:0]   store_byte;
    logic                checksum_bad;
    phase_t              phase;
  } result_t;

endpackage

`default_nettype wire

FILE: design/urs_step.sv
`timescale 1ns / 1ps
`default_nettype none

module urs_step #(
  parameter int ID_WIDTH = urs_pkg::ID_WIDTH_DEF
) (
  input  urs_pkg::item_t   item,
  input  urs_pkg::st_t     st,
  input  logic [ID_WIDTH-1:0] next_id,
  output urs_pkg::st_t     st_nxt,
  output logic [ID_WIDTH-1:0] next_id_nxt,
  output urs_pkg::result_t res
);
  import urs_pkg::*;

  localparam int CMP_W = (ID_WIDTH > MSG_ID_W) ? ID_WIDTH : MSG_ID_W;
  localparam logic [CMP_W-1:0] ID_MASK = CMP_W'({ID_WIDTH{1'b1}});

  logic              id_ok;
  logic              take_up;
  logic              take_data;
  logic              take_end;
  logic              ack;
  logic [SIZE_W-1:0] bytes_inc;

  assign id_ok = ((CMP_W'(item.message_id) & ID_MASK) == CMP_W'(next_id));

  // count saturates at all ones
  assign bytes_inc = (&st.bytes_rcvd) ? st.bytes_rcvd : st.bytes_rcvd + 1'b1;

  always_comb begin
    take_up   = 1'b0;
    take_data = 1'b0;
    take_end  = 1'b0;
    unique case (st.phase)
      PH_WAITING:     take_up   = id_ok && (item.req_type == REQ_UPLOAD);
      PH_DOWNLOADING: take_data = id_ok && (item.req_type == REQ_DATA);
      PH_FINISHED:    take_end  = id_ok && (item.req_type == REQ_END);
      PH_COMPLETE:    ;
      default:        ;
    endcase
  end

  assign ack = take_up || take_end || (take_data && item.seg_last);

  always_comb begin
    st_nxt = st;
    if (take_up) begin
      st_nxt.bytes_rcvd = '0;
      st_nxt.dl_size    = item.file_size;
      st_nxt.phase      = PH_DOWNLOADING;
    end
    if (take_data) begin
      st_nxt.csum       = st.csum ^ item.data_byte;
      st_nxt.bytes_rcvd = bytes_inc;
      if (item.seg_last && (bytes_inc >= st.dl_size)) begin
        st_nxt.phase = PH_FINISHED;
      end
    end
    if (take_end) begin
      st_nxt.phase = PH_COMPLETE;
    end
  end

  assign next_id_nxt = ack ? ID_WIDTH'(next_id + 1'b1) : next_id;

  always_comb begin
    res.accepted     = take_up || take_data || take_end;
    res.ack_valid    = ack;
    res.acked_id     = ack ? MSG_ID_W'(next_id) : '0;
    res.expected_id  = MSG_ID_W'(next_id_nxt);
    res.store_valid  = take_data;
    res.store_byte   = take_data ? item.data_byte : '0;
    res.checksum_bad = take_end && (item.check_sum != st.csum);
    res.phase        = st_nxt.phase;
  end

endmodule

`default_nettype wire

FILE: design/upload_receiver_sequencer_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Receiver side of a sequenced upload: one request in, one result out, one request per
// clock cycle sustained while out_ready keeps the output register free. A request is
// captured in an input register, evaluated against the phase, expected ID, byte count,
// file size and running checksum in a single step, and the result lands in an output
// register, which drives out_valid. The one-request-per-cycle rate is set by the state
// update loop (phase, expected ID, count, checksum), which closes within that single
// step. in_ready stays high while a result waits in the output register as long as the
// input register is free. first_id is written over the APB-style port at address 0 and
// also loads the expected ID while the receiver is still waiting; no clearing pass runs
// after reset.
module upload_receiver_sequencer_top #(
  parameter int ID_WIDTH = urs_pkg::ID_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_req_type,
  input  logic [urs_pkg::MSG_ID_W-1:0]    in_message_id,
  input  logic [urs_pkg::SIZE_W-1:0]      in_file_size,
  input  logic [urs_pkg::BYTE_W-1:0]      in_check_sum,
  input  logic [urs_pkg::BYTE_W-1:0]      in_data_byte,
  input  logic                            in_seg_last,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_accepted,
  output logic                            out_ack_valid,
  output logic [urs_pkg::MSG_ID_W-1:0]    out_acked_id,
  output logic [urs_pkg::MSG_ID_W-1:0]    out_expected_id,
  output logic                            out_store_valid,
  output logic [urs_pkg::BYTE_W-1:0]      out_store_byte,
  output logic                            out_checksum_bad,
  output logic [1:0]                      out_phase,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [urs_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [urs_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [urs_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import urs_pkg::*;

`include "upload_receiver_sequencer_top_macros.svh"

  // configuration
  logic [CFG_DATA_W-1:0] first_id_r;
  logic                  reg_hit;
  logic                  cfg_wr;

  // input register
  logic                  in_vld_r;
  item_t                 in_item_r;

  // receiver state
  st_t                   st_r;
  logic [ID_WIDTH-1:0]   next_id_r;

  // output register
  logic                  out_vld_r;
  result_t               out_res_r;

  // step results
  st_t                   st_nxt;
  logic [ID_WIDTH-1:0]   next_id_nxt;
  result_t               res_nxt;

  logic                  advance;
  logic                  fire;

  // output register frees when empty or being taken
  assign advance  = !out_vld_r || out_ready;
  // request in the input register is evaluated and moved on
  assign fire     = in_vld_r && advance;
  assign in_ready = !in_vld_r || advance;

  // register decode ignores the byte offset
  assign reg_hit = (paddr[CFG_ADDR_W-1:2] == REG_FIRST_ID);
  assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? first_id_r : '0;

  urs_step #(
    .ID_WIDTH (ID_WIDTH)
  ) u_step (
    .item        (in_item_r),
    .st          (st_r),
    .next_id     (next_id_r),
    .st_nxt      (st_nxt),
    .next_id_nxt (next_id_nxt),
    .res         (res_nxt)
  );

  // input register capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r.req_type   <= req_t'(in_req_type);
      in_item_r.message_id <= in_message_id;
      in_item_r.file_size  <= in_file_size;
      in_item_r.check_sum  <= in_check_sum;
      in_item_r.data_byte  <= in_data_byte;
      in_item_r.seg_last   <= in_seg_last;
    end
  end

  // receiver state; a rejected request leaves it as it was
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase      <= PH_WAITING;
      st_r.bytes_rcvd <= '0;
      st_r.dl_size    <= '0;
      st_r.csum       <= '0;
      next_id_r       <= '0;
      first_id_r      <= '0;
    end else begin
      if (fire) begin
        st_r      <= st_nxt;
        next_id_r <= next_id_nxt;
      end
      // the user must send config writes only while idle; the block itself does not enforce it
      if (cfg_wr) begin
        first_id_r <= pwdata;
        if (st_r.phase == PH_WAITING) begin
          next_id_r <= ID_WIDTH'(pwdata);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_accepted     = out_res_r.accepted;
  assign out_ack_valid    = out_res_r.ack_valid;
  assign out_acked_id     = out_res_r.acked_id;
  assign out_expected_id  = out_res_r.expected_id;
  assign out_store_valid  = out_res_r.store_valid;
  assign out_store_byte   = out_res_r.store_byte;
  assign out_checksum_bad = out_res_r.checksum_bad;
  assign out_phase        = out_res_r.phase;

  // complete is terminal until reset
  `URS_ASSERT_NEXT(a_complete_sticks, st_r.phase == PH_COMPLETE, st_r.phase == PH_COMPLETE, "left complete phase")

  // a rejected request changes no state
  `URS_ASSERT_NEXT(a_reject_no_change, fire && !res_nxt.accepted, $stable(st_r) && $stable(next_id_r), "rejected request changed state")

  // every acknowledge advances the expected id by one
  `URS_ASSERT_NEXT(a_ack_bumps_id, fire && res_nxt.ack_valid, next_id_r == ID_WIDTH'($past(next_id_r) + 1'b1), "expected id did not advance")

  // acknowledge and store only come with an accepted request
  `URS_ASSERT_SAME(a_ack_needs_accept, out_vld_r && (out_res_r.ack_valid || out_res_r.store_valid), out_res_r.accepted, "ack or store without accept")

endmodule

`default_nettype wire

FILE: sim/upload_receiver_sequencer_top_tb.sv
`timescale 1ns / 1ps

module upload_receiver_sequencer_top_tb;
  import urs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_CYCLES = 8;

  // register map: index in paddr above the two byte-offset bits
  localparam logic [CFG_ADDR_W-3:0] REG_SPARE = REG_FIRST_ID + 1'b1;
  localparam logic [CFG_ADDR_W-1:0] FIRST_ID_ADDR = {REG_FIRST_ID, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR = {REG_SPARE, 2'b00};

  // what the driver does with one entry of its schedule
  typedef enum logic [1:0] {
    OP_ITEM,
    OP_WRITE,
    OP_READ,
    OP_DRAIN
  } sched_op_t;

  typedef enum logic [1:0] {
    BUS_IDLE,
    BUS_SETUP,
    BUS_ACCESS
  } bus_state_t;

  typedef struct {
    sched_op_t             op;
    item_t                 req;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;
    int unsigned           gap;
  } sched_entry_t;

  logic clk;
  logic rst_n = 1'b0;

  // request channel
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          in_req_type = '0;
  logic [MSG_ID_W-1:0] in_message_id = '0;
  logic [SIZE_W-1:0]   in_file_size = '0;
  logic [BYTE_W-1:0]   in_check_sum = '0;
  logic [BYTE_W-1:0]   in_data_byte = '0;
  logic                in_seg_last = 1'b0;

  // result channel
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_accepted;
  logic                out_ack_valid;
  logic [MSG_ID_W-1:0] out_acked_id;
  logic [MSG_ID_W-1:0] out_expected_id;
  logic                out_store_valid;
  logic [BYTE_W-1:0]   out_store_byte;
  logic                out_checksum_bad;
  logic [1:0]          out_phase;

  // register port
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  upload_receiver_sequencer_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_message_id    (in_message_id),
    .in_file_size     (in_file_size),
    .in_check_sum     (in_check_sum),
    .in_data_byte     (in_data_byte),
    .in_seg_last      (in_seg_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_accepted     (out_accepted),
    .out_ack_valid    (out_ack_valid),
    .out_acked_id     (out_acked_id),
    .out_expected_id  (out_expected_id),
    .out_store_valid  (out_store_valid),
    .out_store_byte   (out_store_byte),
    .out_checksum_bad (out_checksum_bad),
    .out_phase        (out_phase),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // schedule filled up front, consumed by the driver
  sched_entry_t sched_q[$];
  // results the receiver owes us, oldest first
  result_t      owed_results[$];

  // shadow of the receiver state, advanced on every accepted request
  phase_t              rx_phase = PH_WAITING;
  logic [MSG_ID_W-1:0] rx_next_id = '0;
  logic [SIZE_W-1:0]   rx_count = '0;
  logic [SIZE_W-1:0]   rx_size = '0;
  logic [BYTE_W-1:0]   rx_xor = '0;
  logic [MSG_ID_W-1:0] rx_first_id = '0;

  int unsigned err_cnt = 0;
  int unsigned cyc_cnt = 0;
  int unsigned n_items = 0;
  int unsigned idle_left = 0;
  int unsigned stall_left = 0;
  logic        req_taken = 1'b0;
  bus_state_t  bus_state = BUS_IDLE;

  // state used only while building the schedule
  logic [MSG_ID_W-1:0] plan_id;
  logic [BYTE_W-1:0]   plan_xor = '0;

  // result stretches with no stalls, a quarter of the time
  wire sink_calm = ((cyc_cnt / 400) % 4) == 3;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // one step of the receiver: updates the shadow state, returns the result it owes
  function automatic result_t receiver_result(item_t r);
    result_t res;
    logic    id_ok;
    res = '0;
    id_ok = (r.message_id == rx_next_id);
    if (id_ok && rx_phase == PH_WAITING && r.req_type == REQ_UPLOAD) begin
      res.accepted = 1'b1;
      res.ack_valid = 1'b1;
      rx_count = '0;
      rx_size = r.file_size;
      rx_phase = PH_DOWNLOADING;
    end else if (id_ok && rx_phase == PH_DOWNLOADING && r.req_type == REQ_DATA) begin
      res.accepted = 1'b1;
      res.store_valid = 1'b1;
      res.store_byte = r.data_byte;
      rx_xor = rx_xor ^ r.data_byte;
      // byte count sticks at all ones
      if (rx_count != '1) rx_count = rx_count + 1'b1;
      // only the segment's last byte is acknowledged, and only then can it finish
      if (r.seg_last) begin
        res.ack_valid = 1'b1;
        if (rx_count >= rx_size) rx_phase = PH_FINISHED;
      end
    end else if (id_ok && rx_phase == PH_FINISHED && r.req_type == REQ_END) begin
      res.accepted = 1'b1;
      res.ack_valid = 1'b1;
      // a bad checksum is only flagged, the upload still completes
      res.checksum_bad = (r.check_sum != rx_xor);
      rx_phase = PH_COMPLETE;
    end
    if (res.ack_valid) begin
      res.acked_id = rx_next_id;
      rx_next_id = rx_next_id + 1'b1;
    end
    res.expected_id = rx_next_id;
    res.phase = rx_phase;
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t mismatch %s: expected %h, actual %h", $time, name, want_v, got_v);
      err_cnt++;
    end
  endtask

  // schedule helpers

  task automatic push_item(req_t t, logic [MSG_ID_W-1:0] id, logic [SIZE_W-1:0] size,
                           logic [BYTE_W-1:0] cs, logic [BYTE_W-1:0] db, logic last);
    sched_entry_t e;
    e.op = OP_ITEM;
    e.req.req_type = t;
    e.req.message_id = id;
    e.req.file_size = size;
    e.req.check_sum = cs;
    e.req.data_byte = db;
    e.req.seg_last = last;
    e.addr = '0;
    e.data = '0;
    // every fifth window of requests goes back to back
    e.gap = (((n_items / 120) % 5) == 4) ? 0 : pick_gap();
    n_items++;
    sched_q.push_back(e);
  endtask

  task automatic push_bus(sched_op_t op, logic [CFG_ADDR_W-1:0] addr,
                          logic [CFG_DATA_W-1:0] data);
    sched_entry_t e;
    e.op = op;
    e.req = '0;
    e.addr = addr;
    e.data = data;
    e.gap = 0;
    sched_q.push_back(e);
  endtask

  // hold the sender until every owed result has come back
  task automatic push_drain();
    push_bus(OP_DRAIN, '0, '0);
  endtask

  // a request the receiver has to reject; fit is the one type that would pass with plan_id
  task automatic push_noise(req_t fit);
    req_t                t;
    logic [MSG_ID_W-1:0] id;
    logic [MSG_ID_W-1:0] flip;
    flip = $urandom_range(0, 1) ? (32'd1 << $urandom_range(0, 31)) : $urandom;
    if (flip == '0) flip = 32'd1;
    t = req_t'($urandom_range(0, 3));
    id = plan_id;
    if (t == fit || $urandom_range(0, 2) == 0) id = plan_id ^ flip;
    push_item(t, id, $urandom, BYTE_W'($urandom), BYTE_W'($urandom),
              1'($urandom_range(0, 1)));
  endtask

  // stimulus and end of run
  initial begin
    int unsigned         fsize;
    int unsigned         sent;
    int unsigned         seg_len;
    logic [MSG_ID_W-1:0] fid;
    logic [BYTE_W-1:0]   b;
    logic [BYTE_W-1:0]   end_sum;
    bit                  paused;

    paused = 1'b0;

    // waiting phase, first id still at its reset value
    push_bus(OP_READ, FIRST_ID_ADDR, '0);
    push_item(REQ_DATA, '0, '0, '0, 8'hFF, 1'b1);
    push_item(REQ_END, '0, '1, 8'hFF, '0, 1'b0);
    push_item(REQ_OTHER, '0, '1, '0, '0, 1'b1);
    push_item(REQ_UPLOAD, 32'd1, '1, '0, '0, 1'b0);
    push_item(REQ_UPLOAD, '1, '0, '0, '0, 1'b0);

    // a random first id, still waiting: next id follows it
    fid = $urandom;
    push_drain();
    push_bus(OP_WRITE, FIRST_ID_ADDR, fid);
    push_bus(OP_READ, FIRST_ID_ADDR, '0);
    push_item(REQ_UPLOAD, fid + 1'b1, $urandom, '0, '0, 1'b0);
    push_item(REQ_OTHER, fid, $urandom, '1, '1, 1'b1);

    // write to an unmapped index must leave everything alone
    push_drain();
    push_bus(OP_WRITE, SPARE_ADDR, $urandom);
    push_bus(OP_READ, FIRST_ID_ADDR, '0);
    push_item(REQ_DATA, fid, '0, '0, 8'h5A, 1'b1);

    // all-ones first id, so the ID wraps right after the upload request
    push_drain();
    push_bus(OP_WRITE, FIRST_ID_ADDR, '1);
    push_bus(OP_READ, FIRST_ID_ADDR, '0);
    plan_id = '1;
    fsize = $urandom_range(1150, 1300);
    push_item(REQ_UPLOAD, plan_id, fsize, '0, '0, 1'b0);
    plan_id = plan_id + 1'b1;

    // downloading: wrong types with the right id, wrong id with the right type
    push_item(REQ_UPLOAD, plan_id, '1, '0, '0, 1'b0);
    push_item(REQ_END, plan_id, '0, '0, '0, 1'b0);
    push_item(REQ_OTHER, plan_id, '0, '0, '0, 1'b0);
    push_item(REQ_DATA, plan_id ^ 32'h8000_0001, '0, '0, 8'hAA, 1'b1);
    // a two-byte segment with the byte extremes
    push_item(REQ_DATA, plan_id, '0, '0, 8'h00, 1'b0);
    push_item(REQ_DATA, plan_id, '1, '1, 8'hFF, 1'b1);
    plan_xor = 8'hFF;
    sent = 2;
    plan_id = plan_id + 1'b1;

    // random segments until the byte count reaches the file size at a segment end
    while (sent < fsize) begin
      seg_len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      for (int unsigned k = 0; k < seg_len; k++) begin
        if ($urandom_range(0, 7) == 0) push_noise(REQ_DATA);
        b = BYTE_W'($urandom);
        plan_xor = plan_xor ^ b;
        sent++;
        push_item(REQ_DATA, plan_id, $urandom, BYTE_W'($urandom), b, k == seg_len - 1);
        // halfway: let everything drain, then rewrite first id mid-download
        if (!paused && sent >= fsize / 2) begin
          paused = 1'b1;
          push_drain();
          push_bus(OP_WRITE, FIRST_ID_ADDR, $urandom);
          push_bus(OP_READ, FIRST_ID_ADDR, '0);
        end
      end
      plan_id = plan_id + 1'b1;
    end

    // finished: only end upload with the right id gets through
    repeat (15) push_noise(REQ_END);
    push_item(REQ_DATA, plan_id, '0, '0, 8'h33, 1'b1);
    end_sum = $urandom_range(0, 1) ? plan_xor : plan_xor ^ (8'd1 << $urandom_range(0, 7));
    push_item(REQ_END, plan_id, $urandom, end_sum, BYTE_W'($urandom),
              1'($urandom_range(0, 1)));
    plan_id = plan_id + 1'b1;

    // complete: everything is turned away
    repeat (30) push_noise(REQ_OTHER);
    push_drain();
    push_bus(OP_WRITE, FIRST_ID_ADDR, '0);
    push_bus(OP_READ, FIRST_ID_ADDR, '0);
    push_item(REQ_UPLOAD, '0, $urandom, '0, '0, 1'b0);
    push_item(REQ_DATA, plan_id, '0, '0, BYTE_W'($urandom), 1'b1);
    push_item(REQ_END, plan_id, '0, plan_xor, '0, 1'b0);

    while (sched_q.size() != 0 || in_valid || owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // request driver: changes on the falling edge, holds the payload until taken
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !req_taken) begin
        // request still waiting on in_ready
      end else if (idle_left != 0) begin
        in_valid <= 1'b0;
        idle_left <= idle_left - 1;
      end else if (sched_q.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        case (sched_q[0].op)
          OP_ITEM: begin
            in_valid <= 1'b1;
            in_req_type <= sched_q[0].req.req_type;
            in_message_id <= sched_q[0].req.message_id;
            in_file_size <= sched_q[0].req.file_size;
            in_check_sum <= sched_q[0].req.check_sum;
            in_data_byte <= sched_q[0].req.data_byte;
            in_seg_last <= sched_q[0].req.seg_last;
            idle_left <= sched_q[0].gap;
            void'(sched_q.pop_front());
          end
          OP_DRAIN: begin
            in_valid <= 1'b0;
            if (owed_results.size() == 0) void'(sched_q.pop_front());
          end
          default: begin
            // register access: setup, access, then release the bus
            in_valid <= 1'b0;
            case (bus_state)
              BUS_IDLE: begin
                psel <= 1'b1;
                penable <= 1'b0;
                pwrite <= (sched_q[0].op == OP_WRITE);
                paddr <= sched_q[0].addr;
                pwdata <= sched_q[0].data;
                bus_state <= BUS_SETUP;
              end
              BUS_SETUP: begin
                penable <= 1'b1;
                bus_state <= BUS_ACCESS;
              end
              default: begin
                psel <= 1'b0;
                penable <= 1'b0;
                bus_state <= BUS_IDLE;
                void'(sched_q.pop_front());
              end
            endcase
          end
        endcase
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!sink_calm && $urandom_range(0, 9) < 3) stall_left <= pick_gap();
    end
  end

  // monitor: everything sampled on the rising edge
  always @(posedge clk) begin
    item_t   req;
    result_t want;
    if (!rst_n) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= in_valid && in_ready;

      // register port: writes update the shadow, reads are checked
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[CFG_ADDR_W-1:2] == REG_FIRST_ID) begin
            rx_first_id = pwdata;
            // first id only reaches the expected id while still waiting
            if (rx_phase == PH_WAITING) rx_next_id = pwdata;
          end
        end else if (paddr[CFG_ADDR_W-1:2] == REG_FIRST_ID) begin
          check_field("first_id read", rx_first_id, prdata);
        end
      end

      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          $display("%0t result with none expected: expected nothing, actual phase %0d id %h",
                   $time, out_phase, out_expected_id);
          err_cnt++;
        end else begin
          want = owed_results.pop_front();
          check_field("accepted", want.accepted, out_accepted);
          check_field("ack_valid", want.ack_valid, out_ack_valid);
          check_field("acked_id", want.acked_id, out_acked_id);
          check_field("expected_id", want.expected_id, out_expected_id);
          check_field("store_valid", want.store_valid, out_store_valid);
          check_field("store_byte", want.store_byte, out_store_byte);
          check_field("checksum_bad", want.checksum_bad, out_checksum_bad);
          check_field("phase", want.phase, out_phase);
        end
      end

      if (in_valid && in_ready) begin
        req.req_type = req_t'(in_req_type);
        req.message_id = in_message_id;
        req.file_size = in_file_size;
        req.check_sum = in_check_sum;
        req.data_byte = in_data_byte;
        req.seg_last = in_seg_last;
        owed_results.push_back(receiver_result(req));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
